### sv/pcap_bon_pkg.sv
// Shared types, constants and format tables for the capture byte-order normaliser.
package pcap_bon_pkg;

  localparam int unsigned GLOBAL_HEADER_BYTES_DEF = 24;
  localparam int unsigned CMD_QUEUE_DEPTH_DEF     = 4;
  localparam int unsigned CMD_BYTES               = 4;

  localparam logic [31:0] MAGIC_STD_BE  = 32'ha1b2c3d4;
  localparam logic [31:0] MAGIC_STD_LE  = 32'hd4c3b2a1;
  localparam logic [31:0] MAGIC_NSEC_BE = 32'ha1b23c4d;
  localparam logic [31:0] MAGIC_NSEC_LE = 32'h4d3cb2a1;
  localparam logic [31:0] MAGIC_EXT_BE  = 32'ha1b2cd34;
  localparam logic [31:0] MAGIC_EXT_LE  = 32'h34cdb2a1;
  localparam logic [31:0] MAGIC_NSN_BE  = 32'ha1e2cb12;
  localparam logic [31:0] MAGIC_NSN_LE  = 32'h12cbe2a1;

  typedef enum logic [1:0] {
    FMT_STD  = 2'd0,
    FMT_NSEC = 2'd1,
    FMT_EXT  = 2'd2,
    FMT_NSN  = 2'd3
  } fmt_e;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_MAGIC  = 2'd1,
    ERR_FORMAT = 2'd2
  } err_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
    logic       keep_global_header;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_record;
    err_e       error_code;
  } out_word_t;

  // One queued emission: up to four bytes already in output order.
  typedef struct packed {
    logic [CMD_BYTES-1:0][7:0] bytes;
    logic [1:0]                len_m1;
    logic                      eor;
    err_e                      err;
  } cmd_t;

  typedef struct packed {
    logic ok;
    fmt_e fmt;
    logic le;
  } magic_t;

  function automatic magic_t lookup_magic(input logic [31:0] m);
    magic_t r;
    r = '{ok: 1'b1, fmt: FMT_STD, le: 1'b0};
    case (m)
      MAGIC_STD_BE:  r = '{ok: 1'b1, fmt: FMT_STD,  le: 1'b0};
      MAGIC_STD_LE:  r = '{ok: 1'b1, fmt: FMT_STD,  le: 1'b1};
      MAGIC_NSEC_BE: r = '{ok: 1'b1, fmt: FMT_NSEC, le: 1'b0};
      MAGIC_NSEC_LE: r = '{ok: 1'b1, fmt: FMT_NSEC, le: 1'b1};
      MAGIC_EXT_BE:  r = '{ok: 1'b1, fmt: FMT_EXT,  le: 1'b0};
      MAGIC_EXT_LE:  r = '{ok: 1'b1, fmt: FMT_EXT,  le: 1'b1};
      MAGIC_NSN_BE:  r = '{ok: 1'b1, fmt: FMT_NSN,  le: 1'b0};
      MAGIC_NSN_LE:  r = '{ok: 1'b1, fmt: FMT_NSN,  le: 1'b1};
      default:       r = '{ok: 1'b0, fmt: FMT_STD,  le: 1'b0};
    endcase
    return r;
  endfunction

  function automatic logic [3:0] field_count(input fmt_e f);
    logic [3:0] c;
    case (f)
      FMT_EXT: c = 4'd7;
      FMT_NSN: c = 4'd9;
      default: c = 4'd4;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] field_size(input fmt_e f, input logic [3:0] idx);
    logic [2:0] s;
    s = 3'd0;
    case (f)
      FMT_EXT: begin
        case (idx)
          4'd0, 4'd1, 4'd2, 4'd3, 4'd4: s = 3'd4;
          4'd5:                         s = 3'd2;
          4'd6:                         s = 3'd1;
          default:                      s = 3'd0;
        endcase
      end
      FMT_NSN: begin
        case (idx)
          4'd0, 4'd1, 4'd2, 4'd3: s = 3'd4;
          4'd4, 4'd5, 4'd6:       s = 3'd2;
          4'd7, 4'd8:             s = 3'd1;
          default:                s = 3'd0;
        endcase
      end
      default: begin
        s = (idx < 4'd4) ? 3'd4 : 3'd0;
      end
    endcase
    return s;
  endfunction

endpackage

### sv/pcap_bon_front.sv
// Parser: tracks file structure and turns each input word into at most one emission.
module pcap_bon_front import pcap_bon_pkg::*; #(
  parameter int unsigned GLOBAL_HEADER_BYTES = GLOBAL_HEADER_BYTES_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_word_t in_i,
  input  logic     out_le_i,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o
);

  typedef enum logic [4:0] {
    PH_MAGIC   = 5'b00001,
    PH_GLOBAL  = 5'b00010,
    PH_HEADER  = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_DROP    = 5'b10000
  } phase_e;

  localparam logic [31:0] GLOBAL_REST = 32'(GLOBAL_HEADER_BYTES - 4);

  phase_e      phase_q, phase_d, phase_eff;
  logic [1:0]  cnt_q, cnt_d, cnt_eff;
  logic [3:0]  fidx_q, fidx_d, fidx_eff;
  fmt_e        fmt_q, fmt_d;
  logic        lock_v_q, lock_v_d;
  fmt_e        lock_fmt_q, lock_fmt_d;
  logic        le_q, le_d;
  logic [31:0] rem_q, rem_d;
  logic        keep_q, keep_d;
  logic [3:0][7:0] buf_q, buf_d;
  logic [3:0][7:0] f;
  magic_t      mg;
  logic [3:0]  fi;
  logic [2:0]  size;
  logic [1:0]  sel;
  logic        rev;
  logic [31:0] len;
  logic [31:0] rem_new;
  logic        cmd_valid;
  cmd_t        cmd;

  always_comb begin
    phase_eff = in_i.file_start ? PH_MAGIC : phase_q;
    cnt_eff   = in_i.file_start ? 2'd0 : cnt_q;
    fidx_eff  = in_i.file_start ? 4'd0 : fidx_q;
    keep_d    = in_i.file_start ? in_i.keep_global_header : keep_q;

    phase_d    = phase_eff;
    cnt_d      = cnt_eff;
    fidx_d     = fidx_eff;
    fmt_d      = fmt_q;
    lock_v_d   = lock_v_q;
    lock_fmt_d = lock_fmt_q;
    le_d       = le_q;
    rem_d      = rem_q;
    buf_d      = buf_q;
    cmd_valid  = 1'b0;
    cmd        = '0;
    sel        = 2'd0;
    rev        = 1'b0;
    rem_new    = rem_q;

    for (int i = 0; i < 4; i++) begin
      f[i] = (cnt_eff == 2'(i)) ? in_i.data_byte : buf_q[i];
    end
    mg   = lookup_magic({f[0], f[1], f[2], f[3]});
    fi   = (fidx_eff < field_count(fmt_q)) ? fidx_eff : 4'd0;
    size = field_size(fmt_q, fi);
    len  = le_q ? {f[3], f[2], f[1], f[0]} : {f[0], f[1], f[2], f[3]};

    unique case (phase_eff)
      PH_MAGIC: begin
        buf_d[cnt_eff] = in_i.data_byte;
        if (cnt_eff == 2'd3) begin
          cnt_d = 2'd0;
          if (!mg.ok) begin
            phase_d   = PH_DROP;
            cmd_valid = 1'b1;
            cmd.err   = ERR_MAGIC;
          end else if (lock_v_q && lock_fmt_q != mg.fmt) begin
            phase_d   = PH_DROP;
            cmd_valid = 1'b1;
            cmd.err   = ERR_FORMAT;
          end else begin
            lock_v_d   = 1'b1;
            lock_fmt_d = mg.fmt;
            fmt_d      = mg.fmt;
            le_d       = mg.le;
            fidx_d     = 4'd0;
            rem_d      = GLOBAL_REST;
            phase_d    = PH_GLOBAL;
            if (keep_d) begin
              cmd_valid  = 1'b1;
              cmd.bytes  = f;
              cmd.len_m1 = 2'd3;
            end
          end
        end else begin
          cnt_d = cnt_eff + 2'd1;
        end
      end
      PH_GLOBAL: begin
        if (keep_d) begin
          cmd_valid    = 1'b1;
          cmd.bytes[0] = in_i.data_byte;
        end
        rem_d = rem_q - 32'd1;
        if (rem_q == 32'd1) begin
          phase_d = PH_HEADER;
        end
      end
      PH_HEADER: begin
        fidx_d         = fi;
        buf_d[cnt_eff] = in_i.data_byte;
        if (({1'b0, cnt_eff} + 3'd1) < size) begin
          cnt_d = cnt_eff + 2'd1;
        end else begin
          cnt_d      = 2'd0;
          rev        = le_q != out_le_i;
          cmd_valid  = 1'b1;
          cmd.len_m1 = 2'(size - 3'd1);
          for (int i = 0; i < 4; i++) begin
            sel          = rev ? 2'(size - 3'd1 - 3'(i)) : 2'(i);
            cmd.bytes[i] = f[sel];
          end
          if (fi == 4'd2) begin
            rem_new = len;
          end
          rem_d  = rem_new;
          fidx_d = fi + 4'd1;
          if ((fi + 4'd1) >= field_count(fmt_q)) begin
            fidx_d  = 4'd0;
            phase_d = (rem_new != 32'd0) ? PH_PAYLOAD : PH_HEADER;
          end
        end
      end
      PH_PAYLOAD: begin
        cmd_valid    = 1'b1;
        cmd.bytes[0] = in_i.data_byte;
        cmd.eor      = rem_q == 32'd1;
        rem_d        = rem_q - 32'd1;
        if (rem_q == 32'd1) begin
          phase_d = PH_HEADER;
          cnt_d   = 2'd0;
          fidx_d  = 4'd0;
        end
      end
      PH_DROP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_MAGIC;
      cnt_q      <= '0;
      fidx_q     <= '0;
      fmt_q      <= FMT_STD;
      lock_v_q   <= 1'b0;
      lock_fmt_q <= FMT_STD;
      le_q       <= 1'b0;
      rem_q      <= '0;
      keep_q     <= 1'b0;
    end else if (in_valid_i) begin
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      fidx_q     <= fidx_d;
      fmt_q      <= fmt_d;
      lock_v_q   <= lock_v_d;
      lock_fmt_q <= lock_fmt_d;
      le_q       <= le_d;
      rem_q      <= rem_d;
      keep_q     <= keep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      buf_q <= buf_d;
    end
  end

  assign cmd_valid_o = in_valid_i && cmd_valid;
  assign cmd_o       = cmd;

endmodule

### sv/pcap_bon_queue.sv
// Short emission queue between parser and serialiser.
module pcap_bon_queue import pcap_bon_pkg::*; #(
  parameter int unsigned DEPTH = CMD_QUEUE_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  cmd_t wr_data_i,
  input  logic rd_i,
  output cmd_t rd_data_o,
  output logic full_o,
  output logic nonempty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  cmd_t          mem_q [DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;
  logic          do_wr, do_rd;

  assign full_o     = cnt_q == CW'(DEPTH);
  assign nonempty_o = cnt_q != '0;
  assign do_wr      = wr_i && !full_o;
  assign do_rd      = rd_i && nonempty_o;
  assign rd_data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) begin
        wp_q <= (wp_q == LAST) ? '0 : wp_q + PW'(1);
      end
      if (do_rd) begin
        rp_q <= (rp_q == LAST) ? '0 : rp_q + PW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

endmodule

### sv/pcap_bon_back.sv
// Serialiser: holds one emission and hands its bytes out one word at a time.
module pcap_bon_back import pcap_bon_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_nonempty_i,
  input  cmd_t      q_data_i,
  output logic      q_rd_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_word_t out_o
);

  cmd_t       cur_q;
  logic       valid_q;
  logic [1:0] idx_q;
  logic       last, load;

  assign last   = idx_q == cur_q.len_m1;
  assign load   = !valid_q || (pop_i && last);
  assign q_rd_o = load && q_nonempty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load) begin
      valid_q <= q_nonempty_i;
      idx_q   <= '0;
    end else if (pop_i) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      cur_q <= q_data_i;
    end
  end

  assign empty_o             = !valid_q;
  assign out_o.out_byte      = cur_q.bytes[idx_q];
  assign out_o.end_of_record = cur_q.eor && last;
  assign out_o.error_code    = cur_q.err;

endmodule

### sv/pcap_record_byte_order_normalizer_top.sv
// Top level of the capture byte-order normaliser: parser, queue and serialiser.
// With queue and serialiser empty, an accepted word is written into the queue, then loaded into
// the serialiser's holding register and shown as the first result word.
// Throughput: one input word per cycle while the queue has room; each field emits up to four
// result words, one per cycle of pop, set by the serialiser; the queue absorbs header bursts.
// Reset (rst_ni low, asynchronous): parser to magic phase, no format locked, queue and serialiser empty.
module pcap_record_byte_order_normalizer_top import pcap_bon_pkg::*; #(
  parameter int unsigned GLOBAL_HEADER_BYTES = GLOBAL_HEADER_BYTES_DEF,
  parameter int unsigned CMD_QUEUE_DEPTH     = CMD_QUEUE_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_word_t  in_i,
  output logic      empty,
  input  logic      pop,
  output out_word_t out_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_wdata_i
);

  logic out_le_q;
  logic in_valid;
  logic cmd_valid;
  cmd_t cmd, q_data;
  logic q_full, q_nonempty, q_rd;

  assign cfg_ready_o = 1'b1;
  assign full        = q_full;
  assign in_valid    = push && !q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_le_q <= 1'b0;
    end else if (cfg_valid_i) begin
      out_le_q <= cfg_wdata_i;
    end
  end

  pcap_bon_front #(
    .GLOBAL_HEADER_BYTES(GLOBAL_HEADER_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_i       (in_i),
    .out_le_i   (out_le_q),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd)
  );

  pcap_bon_queue #(
    .DEPTH(CMD_QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (cmd_valid),
    .wr_data_i (cmd),
    .rd_i      (q_rd),
    .rd_data_o (q_data),
    .full_o    (q_full),
    .nonempty_o(q_nonempty)
  );

  pcap_bon_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_nonempty_i(q_nonempty),
    .q_data_i    (q_data),
    .q_rd_o      (q_rd),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_o       (out_o)
  );

`ifndef SYNTHESIS
  a_err_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_o.error_code != ERR_NONE) |-> (out_o.out_byte == 8'd0))
    else $error("error word carries a data byte");

  a_err_no_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_o.error_code != ERR_NONE) |-> !out_o.end_of_record)
    else $error("error word flagged as end of record");

  a_no_write_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !cmd_valid)
    else $error("parser emitted into a full queue");
`endif

endmodule
